[rtl/ipta_pkg.sv]
// ----------------------------------------------------------------------------
// ipta_pkg: shared types, codes and the per-character parse step
// Phase codes, status codes, character constants and the combinational
// function that advances the parser context by one character.
// ----------------------------------------------------------------------------
package ipta_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_LCOLON  = 4'd1,
    PH_HCOLON  = 4'd2,
    PH_GROUP_H = 4'd3,
    PH_TSTART  = 4'd4,
    PH_GROUP_T = 4'd5,
    PH_TCOLON  = 4'd6,
    PH_V4H     = 4'd7,
    PH_V4T     = 4'd8,
    PH_PREFIX  = 4'd9
  } phase_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HEX_EXP    = 3'd1;
  localparam logic [2:0] ST_COLON_EXP  = 3'd2;
  localparam logic [2:0] ST_OVERLONG   = 3'd3;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  localparam logic [9:0] DEC_BAD     = 10'd1023;
  localparam logic [7:0] PREFIX_NONE = 8'd128;
  localparam logic [7:0] PREFIX_MAX  = 8'd128;
  localparam logic [7:0] PREFIX_SAT  = 8'd255;
  localparam int         GROUPS      = 8;

  // group k sits at index k
  typedef logic [GROUPS-1:0][15:0] groups_t;

  typedef struct packed {
    groups_t     head_groups;
    logic [3:0]  head_count;
    logic [3:0]  tail_count;
    phase_t      phase;
    logic [15:0] hex_acc;
    logic [2:0]  digit_count;
    logic [9:0]  dec_acc;
    logic [1:0]  octet_index;
    logic [31:0] ipv4_word;
    logic [7:0]  prefix_acc;
  } ctx_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic        has_prefix;
    logic [2:0]  status;
    logic [7:0]  end_char;
  } res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    ctx_t    ctx;
    groups_t tail;
    logic    emit;
    res_t    res;
  } step_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic ctx_t ctx_clear();
    ctx_t r;
    r = '0;
    r.phase = PH_START;
    return r;
  endfunction

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = c[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.val = c[3:0];
    end else if (c >= CH_LA && c <= CH_LF) begin
      r.val = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.val = 4'(c - CH_UA + 8'd10);
    end else begin
      r.ok  = 1'b0;
      r.val = '0;
    end
    return r;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_SLASH) || (c == CH_NUL);
  endfunction

  function automatic logic octet_ok(input ctx_t s);
    return (s.digit_count >= 3'd1) && (s.digit_count <= 3'd3) && (s.dec_acc <= 10'd255);
  endfunction

  function automatic step_t no_emit(input ctx_t s, input groups_t t);
    step_t r;
    r.ctx  = s;
    r.tail = t;
    r.emit = 1'b0;
    r.res  = '0;
    return r;
  endfunction

  function automatic step_t emit_err(input groups_t t, input logic [2:0] st,
                                     input logic [7:0] c);
    step_t r;
    r.ctx          = ctx_clear();
    r.tail         = t;
    r.emit         = 1'b1;
    r.res          = '0;
    r.res.status   = st;
    r.res.end_char = c;
    return r;
  endfunction

  // tail groups are a shift line, newest at the top index, so after n pushes
  // they already sit in the last n group positions
  function automatic step_t emit_ok(input ctx_t s, input groups_t t, input logic has,
                                    input logic [7:0] plen, input logic [7:0] c);
    step_t      r;
    groups_t    v;
    logic [3:0] n;
    n = (s.tail_count > 4'd7) ? 4'd7 : s.tail_count;
    for (int k = 0; k < GROUPS; k++) begin
      v[k] = ((5'(k) + {1'b0, n}) >= 5'd8) ? t[k] : s.head_groups[k];
    end
    r.ctx            = ctx_clear();
    r.tail           = t;
    r.emit           = 1'b1;
    r.res.addr_hi    = {v[0], v[1], v[2], v[3]};
    r.res.addr_lo    = {v[4], v[5], v[6], v[7]};
    r.res.prefix_len = plen;
    r.res.has_prefix = has;
    r.res.status     = ST_OK;
    r.res.end_char   = c;
    return r;
  endfunction

  function automatic step_t finish(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t r;
    ctx_t  n;
    n = s;
    if (c == CH_SLASH) begin
      n.phase       = PH_PREFIX;
      n.prefix_acc  = '0;
      n.digit_count = '0;
      r = no_emit(n, t);
    end else begin
      r = emit_ok(s, t, 1'b0, PREFIX_NONE, c);
    end
    return r;
  endfunction

  function automatic step_t tail_done(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t r;
    if (({1'b0, s.head_count} + {1'b0, s.tail_count}) > 5'd7) begin
      r = emit_err(t, ST_OVERLONG, c);
    end else begin
      r = finish(s, t, c);
    end
    return r;
  endfunction

  function automatic ctx_t start_group(input ctx_t s, input logic [3:0] d,
                                       input phase_t ph);
    ctx_t n;
    n = s;
    n.hex_acc     = {12'd0, d};
    n.digit_count = 3'd1;
    n.dec_acc     = (d < 4'd10) ? {6'd0, d} : DEC_BAD;
    n.phase       = ph;
    return n;
  endfunction

  function automatic ctx_t add_hex(input ctx_t s, input logic [3:0] d);
    ctx_t        n;
    logic [13:0] prod;
    n = s;
    prod = 14'(s.dec_acc) * 14'd10 + 14'(d);
    n.hex_acc     = {s.hex_acc[11:0], d};
    n.digit_count = s.digit_count + 3'd1;
    n.dec_acc     = (d < 4'd10 && prod < 14'(DEC_BAD)) ? prod[9:0] : DEC_BAD;
    return n;
  endfunction

  function automatic ctx_t begin_v4(input ctx_t s, input phase_t ph);
    ctx_t n;
    n = s;
    n.ipv4_word   = {24'd0, s.dec_acc[7:0]};
    n.octet_index = 2'd1;
    n.dec_acc     = '0;
    n.digit_count = '0;
    n.phase       = ph;
    return n;
  endfunction

  function automatic step_t close_head(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t r;
    ctx_t  n;
    n = s;
    n.head_groups[s.head_count[2:0]] = s.hex_acc;
    n.head_count = s.head_count + 4'd1;
    if (n.head_count >= 4'd8) begin
      r = finish(n, t, c);
    end else if (c == CH_COLON) begin
      n.phase = PH_HCOLON;
      r = no_emit(n, t);
    end else begin
      r = emit_err(t, ST_COLON_EXP, c);
    end
    return r;
  endfunction

  function automatic step_t close_tail(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t   r;
    ctx_t    n;
    groups_t nt;
    n  = s;
    nt = {s.hex_acc, t[GROUPS-1:1]};
    n.tail_count = s.tail_count + 4'd1;
    if (n.tail_count >= 4'd8) begin
      r = emit_err(nt, ST_OVERLONG, c);
    end else if (is_term(c)) begin
      r = tail_done(n, nt, c);
    end else if (c == CH_COLON) begin
      n.phase = PH_TCOLON;
      r = no_emit(n, nt);
    end else begin
      r = emit_err(nt, ST_COLON_EXP, c);
    end
    return r;
  endfunction

  function automatic step_t v4_fail(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t r;
    if (s.phase == PH_V4T && ({1'b0, s.tail_count} + 5'd1) >= 5'd8) begin
      r = emit_err(t, ST_OVERLONG, c);
    end else begin
      r = emit_err(t, ST_COLON_EXP, c);
    end
    return r;
  endfunction

  function automatic step_t step_v4(input ctx_t s, input groups_t t, input logic [7:0] c,
                                    input logic [3:0] dig, input logic is_dec);
    step_t       r;
    ctx_t        n;
    groups_t     nt;
    logic [13:0] prod;
    logic [31:0] w;
    logic        oct;
    n    = s;
    prod = 14'(s.dec_acc) * 14'd10 + 14'(dig);
    oct  = octet_ok(s);
    w    = {s.ipv4_word[23:0], s.dec_acc[7:0]};
    if (is_dec) begin
      n.dec_acc = (prod < 14'(DEC_BAD)) ? prod[9:0] : DEC_BAD;
      if (s.digit_count < 3'd7) begin
        n.digit_count = s.digit_count + 3'd1;
      end
      r = no_emit(n, t);
    end else if (c == CH_DOT && s.octet_index < 2'd3) begin
      if (!oct) begin
        r = v4_fail(s, t, c);
      end else begin
        n.ipv4_word   = w;
        n.octet_index = s.octet_index + 2'd1;
        n.dec_acc     = '0;
        n.digit_count = '0;
        r = no_emit(n, t);
      end
    end else if (s.octet_index != 2'd3 || !oct) begin
      r = v4_fail(s, t, c);
    end else if (s.phase == PH_V4H) begin
      n.head_groups[6] = w[31:16];
      n.head_groups[7] = w[15:0];
      n.head_count     = 4'd8;
      r = finish(n, t, c);
    end else if (!is_term(c)) begin
      r = v4_fail(s, t, c);
    end else begin
      // upper half pushed first, lower half lands on top
      nt = {w[15:0], w[31:16], t[GROUPS-1:2]};
      n.tail_count = s.tail_count + 4'd2;
      r = tail_done(n, nt, c);
    end
    return r;
  endfunction

  function automatic step_t parse_char(input ctx_t s, input groups_t t, input logic [7:0] c);
    step_t       r;
    ctx_t        n;
    hex_t        h;
    logic        dec;
    logic [11:0] pt;
    h   = hex_val(c);
    dec = (c >= CH_ZERO) && (c <= CH_NINE);
    pt  = 12'(s.prefix_acc) * 12'd10 + 12'(h.val);
    n   = s;
    unique case (s.phase)
      PH_LCOLON: begin
        if (c == CH_COLON) begin
          n.phase = PH_TSTART;
          r = no_emit(n, t);
        end else begin
          r = emit_err(t, ST_HEX_EXP, c);
        end
      end
      PH_HCOLON: begin
        if (c == CH_COLON) begin
          n.phase = PH_TSTART;
          r = no_emit(n, t);
        end else if (h.ok) begin
          r = no_emit(start_group(s, h.val, PH_GROUP_H), t);
        end else begin
          r = emit_err(t, ST_HEX_EXP, c);
        end
      end
      PH_GROUP_H: begin
        if (h.ok && s.digit_count < 3'd4) begin
          r = no_emit(add_hex(s, h.val), t);
        end else if (c == CH_DOT && s.head_count == 4'd6 && octet_ok(s)) begin
          r = no_emit(begin_v4(s, PH_V4H), t);
        end else begin
          r = close_head(s, t, c);
        end
      end
      PH_TSTART: begin
        if (is_term(c)) begin
          r = tail_done(s, t, c);
        end else if (h.ok) begin
          r = no_emit(start_group(s, h.val, PH_GROUP_T), t);
        end else begin
          r = emit_err(t, ST_HEX_EXP, c);
        end
      end
      PH_GROUP_T: begin
        if (h.ok && s.digit_count < 3'd4) begin
          r = no_emit(add_hex(s, h.val), t);
        end else if (c == CH_DOT && octet_ok(s)) begin
          r = no_emit(begin_v4(s, PH_V4T), t);
        end else begin
          r = close_tail(s, t, c);
        end
      end
      PH_TCOLON: begin
        if (h.ok) begin
          r = no_emit(start_group(s, h.val, PH_GROUP_T), t);
        end else begin
          r = emit_err(t, ST_HEX_EXP, c);
        end
      end
      PH_V4H, PH_V4T: begin
        r = step_v4(s, t, c, h.val, dec);
      end
      PH_PREFIX: begin
        if (dec) begin
          n.prefix_acc  = (pt < 12'(PREFIX_SAT)) ? pt[7:0] : PREFIX_SAT;
          n.digit_count = 3'd1;
          r = no_emit(n, t);
        end else if (s.digit_count == 3'd0 || s.prefix_acc > PREFIX_MAX) begin
          r = emit_err(t, ST_BAD_PREFIX, c);
        end else begin
          r = emit_ok(s, t, 1'b1, s.prefix_acc, c);
        end
      end
      default: begin
        n = ctx_clear();
        if (c == CH_COLON) begin
          n.phase = PH_LCOLON;
          r = no_emit(n, t);
        end else if (h.ok) begin
          r = no_emit(start_group(n, h.val, PH_GROUP_H), t);
        end else begin
          r = emit_err(t, ST_HEX_EXP, c);
        end
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/ipta_in_stage.sv]
// ----------------------------------------------------------------------------
// ipta_in_stage: input register
// Holds one character item; releases it when the result side can move.
// ----------------------------------------------------------------------------
module ipta_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_ch,
  input  logic              in_last,
  input  logic              advance,
  output logic              go,
  output ipta_pkg::item_t   item
);

  logic            valid_r;
  ipta_pkg::item_t item_r;

  assign in_stall = valid_r && !advance;
  assign go       = valid_r && advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.ch   <= in_ch;
      item_r.last <= in_last;
    end
  end

endmodule

[rtl/ipta_engine.sv]
// ----------------------------------------------------------------------------
// ipta_engine: parser context and per-character update
// Applies the parse step to the held item, and a second time with NUL when
// the item closes the text without having produced a result.
// ----------------------------------------------------------------------------
module ipta_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  ipta_pkg::item_t   item,
  output logic              emit,
  output ipta_pkg::res_t    res
);

  ipta_pkg::ctx_t    ctx_r, ctx_nxt;
  ipta_pkg::groups_t tail_r, tail_nxt;
  ipta_pkg::step_t   pass1, pass2;

  always_comb begin
    pass1 = ipta_pkg::parse_char(ctx_r, tail_r, item.ch);
    if (!pass1.emit && item.last) begin
      pass2 = ipta_pkg::parse_char(pass1.ctx, pass1.tail, ipta_pkg::CH_NUL);
    end else begin
      pass2 = pass1;
    end
    ctx_nxt  = pass2.ctx;
    tail_nxt = pass2.tail;
  end

  assign emit = go && pass2.emit;
  assign res  = pass2.res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= ipta_pkg::ctx_clear();
    end else if (go) begin
      ctx_r <= ctx_nxt;
    end
  end

  // tail groups are only read behind tail_count, so no reset
  always_ff @(posedge clk) begin
    if (go) begin
      tail_r <= tail_nxt;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (ctx_r.phase == ipta_pkg::PH_START && ctx_r.head_count == 4'd0
              && ctx_r.tail_count == 4'd0))
    else $error("context not cleared after result");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.head_count <= 4'd8)
    else $error("head group count out of range");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.tail_count <= 4'd7)
    else $error("tail group count out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.status != ipta_pkg::ST_OK) |->
      (res.addr_hi == 64'd0 && res.addr_lo == 64'd0 && !res.has_prefix))
    else $error("error result carries address data");

endmodule

[rtl/ipta_out_stage.sv]
// ----------------------------------------------------------------------------
// ipta_out_stage: result register
// Holds one result item until taken; tells the input side when it can move.
// ----------------------------------------------------------------------------
module ipta_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ipta_pkg::res_t    res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_addr_hi,
  output logic [63:0]       out_addr_lo,
  output logic [7:0]        out_prefix_len,
  output logic              out_has_prefix,
  output logic [2:0]        out_status,
  output logic [7:0]        out_end_char
);

  logic           valid_r;
  ipta_pkg::res_t res_r;

  assign advance        = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_addr_hi    = res_r.addr_hi;
  assign out_addr_lo    = res_r.addr_lo;
  assign out_prefix_len = res_r.prefix_len;
  assign out_has_prefix = res_r.has_prefix;
  assign out_status     = res_r.status;
  assign out_end_char   = res_r.end_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= res;
    end
  end

endmodule

[rtl/ipv6_text_address_parser.sv]
// ----------------------------------------------------------------------------
// ipv6_text_address_parser: IPv6 address text to 128-bit address
// The closing character is first held in the input register; the parse step
// then loads the result register, which raises out_valid. Throughput: one
// character per cycle; the input stalls only while the result register is
// full and out_stall is high.
// Reset: synchronous rst_n empties both registers and returns the parser to
// the start of an address.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_addr_hi,
  output logic [63:0] out_addr_lo,
  output logic [7:0]  out_prefix_len,
  output logic        out_has_prefix,
  output logic [2:0]  out_status,
  output logic [7:0]  out_end_char
);

  logic            advance;
  logic            go;
  logic            emit;
  ipta_pkg::item_t item;
  ipta_pkg::res_t  res;

  ipta_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .advance  (advance),
    .go       (go),
    .item     (item)
  );

  ipta_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .emit  (emit),
    .res   (res)
  );

  ipta_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (emit),
    .res            (res),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_addr_hi    (out_addr_hi),
    .out_addr_lo    (out_addr_lo),
    .out_prefix_len (out_prefix_len),
    .out_has_prefix (out_has_prefix),
    .out_status     (out_status),
    .out_end_char   (out_end_char)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_default_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ipta_pkg::ST_OK && !out_has_prefix) |->
      (out_prefix_len == ipta_pkg::PREFIX_NONE))
    else $error("missing prefix not reported as full length");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ipta_pkg::ST_BAD_PREFIX))
    else $error("status code out of range");

endmodule

[tb/sv/ipv6_text_address_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_tb: self-checking bench for the IPv6 text parser
// Feeds address text one character per item: a short directed set, then
// mostly well-formed random addresses (gaps, dotted tails, prefixes, broken
// variants) and some noise. A scoreboard runs its own character-level model
// and checks every result field against it, under random stalls on both ends.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  // Character-level model of the parser plus the queue of predicted addresses.
  class address_scoreboard;
    ipta_pkg::res_t pending_addrs[$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    produced;
    int unsigned    with_prefix;
    int unsigned    status_seen[5];

    logic [15:0]      head_g[8];
    logic [15:0]      tail_g[8];
    logic [3:0]       n_head;
    logic [3:0]       n_tail;
    ipta_pkg::phase_t ph;
    logic [15:0]      hex_acc;
    logic [2:0]       ndig;
    logic [9:0]       dec_acc;
    logic [1:0]       oct_idx;
    logic [31:0]      v4w;
    logic [7:0]       pfx;

    function new();
      errors = 0;
      checked = 0;
      produced = 0;
      with_prefix = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear();
    endfunction

    function void clear();
      foreach (head_g[i]) head_g[i] = '0;
      foreach (tail_g[i]) tail_g[i] = '0;
      n_head = '0;
      n_tail = '0;
      ph = ipta_pkg::PH_START;
      hex_acc = '0;
      ndig = '0;
      dec_acc = '0;
      oct_idx = '0;
      v4w = '0;
      pfx = '0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= ipta_pkg::CH_ZERO && c <= ipta_pkg::CH_NINE)
        return int'(c - ipta_pkg::CH_ZERO);
      if (c >= ipta_pkg::CH_LA && c <= ipta_pkg::CH_LF) return int'(c - ipta_pkg::CH_LA) + 10;
      if (c >= ipta_pkg::CH_UA && c <= ipta_pkg::CH_UF) return int'(c - ipta_pkg::CH_UA) + 10;
      return -1;
    endfunction

    function bit is_end(logic [7:0] c);
      return c == ipta_pkg::CH_SPACE || c == ipta_pkg::CH_TAB ||
             c == ipta_pkg::CH_SLASH || c == ipta_pkg::CH_NUL;
    endfunction

    function bit fault(logic [2:0] st, logic [7:0] c);
      ipta_pkg::res_t r;
      r = '0;
      r.status = st;
      r.end_char = c;
      pending_addrs.push_back(r);
      produced++;
      status_seen[st]++;
      clear();
      return 1'b1;
    endfunction

    function bit good(bit has, logic [7:0] plen, logic [7:0] c);
      logic [15:0]    v[8];
      int             n;
      ipta_pkg::res_t r;
      v = head_g;
      n = (n_tail > 4'd7) ? 7 : int'(n_tail);
      // tail groups are right-aligned, the gap in between stays zero
      for (int k = 0; k < n; k++) v[8 - n + k] = tail_g[k];
      r.addr_hi = {v[0], v[1], v[2], v[3]};
      r.addr_lo = {v[4], v[5], v[6], v[7]};
      r.prefix_len = plen;
      r.has_prefix = has;
      r.status = ipta_pkg::ST_OK;
      r.end_char = c;
      pending_addrs.push_back(r);
      produced++;
      status_seen[ipta_pkg::ST_OK]++;
      if (has) with_prefix++;
      clear();
      return 1'b1;
    endfunction

    function bit wrap_up(logic [7:0] c);
      if (c == ipta_pkg::CH_SLASH) begin
        ph = ipta_pkg::PH_PREFIX;
        pfx = '0;
        ndig = '0;
        return 1'b0;
      end
      return good(1'b0, ipta_pkg::PREFIX_NONE, c);
    endfunction

    function bit tail_end(logic [7:0] c);
      if (int'(n_head) + int'(n_tail) > 7) return fault(ipta_pkg::ST_OVERLONG, c);
      return wrap_up(c);
    endfunction

    function void open_group(int d, ipta_pkg::phase_t p);
      hex_acc = 16'(d);
      ndig = 3'd1;
      dec_acc = (d < 10) ? 10'(d) : ipta_pkg::DEC_BAD;
      ph = p;
    endfunction

    function void more_hex(int d);
      int t;
      t = int'(dec_acc) * 10 + d;
      hex_acc = {hex_acc[11:0], 4'(d)};
      ndig = ndig + 3'd1;
      dec_acc = (d < 10 && t < 1023) ? 10'(t) : ipta_pkg::DEC_BAD;
    endfunction

    function bit oct_valid();
      return ndig >= 3'd1 && ndig <= 3'd3 && dec_acc <= 10'd255;
    endfunction

    // the group read so far becomes the first octet
    function void enter_v4(ipta_pkg::phase_t p);
      v4w = {22'd0, dec_acc};
      oct_idx = 2'd1;
      dec_acc = '0;
      ndig = '0;
      ph = p;
    endfunction

    function bit seal_head(logic [7:0] c);
      head_g[n_head[2:0]] = hex_acc;
      n_head = n_head + 4'd1;
      if (n_head >= 4'd8) return wrap_up(c);
      if (c == ipta_pkg::CH_COLON) begin
        ph = ipta_pkg::PH_HCOLON;
        return 1'b0;
      end
      return fault(ipta_pkg::ST_COLON_EXP, c);
    endfunction

    function bit seal_tail(logic [7:0] c);
      tail_g[n_tail[2:0]] = hex_acc;
      n_tail = n_tail + 4'd1;
      if (n_tail >= 4'd8) return fault(ipta_pkg::ST_OVERLONG, c);
      if (is_end(c)) return tail_end(c);
      if (c == ipta_pkg::CH_COLON) begin
        ph = ipta_pkg::PH_TCOLON;
        return 1'b0;
      end
      return fault(ipta_pkg::ST_COLON_EXP, c);
    endfunction

    function bit v4_bad(logic [7:0] c);
      if (ph == ipta_pkg::PH_V4T && int'(n_tail) + 1 >= 8)
        return fault(ipta_pkg::ST_OVERLONG, c);
      return fault(ipta_pkg::ST_COLON_EXP, c);
    endfunction

    function bit v4_char(logic [7:0] c);
      int          t;
      logic [31:0] w;
      if (c >= ipta_pkg::CH_ZERO && c <= ipta_pkg::CH_NINE) begin
        t = int'(dec_acc) * 10 + int'(c - ipta_pkg::CH_ZERO);
        dec_acc = (t < 1023) ? 10'(t) : ipta_pkg::DEC_BAD;
        if (ndig < 3'd7) ndig = ndig + 3'd1;
        return 1'b0;
      end
      if (c == ipta_pkg::CH_DOT && oct_idx < 2'd3) begin
        if (!oct_valid()) return v4_bad(c);
        v4w = {v4w[23:0], dec_acc[7:0]};
        oct_idx = oct_idx + 2'd1;
        dec_acc = '0;
        ndig = '0;
        return 1'b0;
      end
      if (oct_idx != 2'd3 || !oct_valid()) return v4_bad(c);
      w = {v4w[23:0], dec_acc[7:0]};
      if (ph == ipta_pkg::PH_V4H) begin
        head_g[6] = w[31:16];
        head_g[7] = w[15:0];
        n_head = 4'd8;
        return wrap_up(c);
      end
      if (!is_end(c)) return v4_bad(c);
      if (n_tail < 4'd8) tail_g[n_tail[2:0]] = w[31:16];
      if (int'(n_tail) + 1 < 8) tail_g[n_tail[2:0] + 3'd1] = w[15:0];
      n_tail = n_tail + 4'd2;
      return tail_end(c);
    endfunction

    // one character; returns 1 when a result, address or error, is produced
    function bit decode_char(logic [7:0] c);
      int d;
      int t;
      d = hex_digit(c);
      case (ph)
        ipta_pkg::PH_LCOLON: begin
          if (c == ipta_pkg::CH_COLON) begin
            ph = ipta_pkg::PH_TSTART;
            return 1'b0;
          end
          return fault(ipta_pkg::ST_HEX_EXP, c);
        end
        ipta_pkg::PH_HCOLON: begin
          if (c == ipta_pkg::CH_COLON) begin
            ph = ipta_pkg::PH_TSTART;
            return 1'b0;
          end
          if (d >= 0) begin
            open_group(d, ipta_pkg::PH_GROUP_H);
            return 1'b0;
          end
          return fault(ipta_pkg::ST_HEX_EXP, c);
        end
        ipta_pkg::PH_GROUP_H: begin
          if (d >= 0 && ndig < 3'd4) begin
            more_hex(d);
            return 1'b0;
          end
          if (c == ipta_pkg::CH_DOT && n_head == 4'd6 && oct_valid()) begin
            enter_v4(ipta_pkg::PH_V4H);
            return 1'b0;
          end
          return seal_head(c);
        end
        ipta_pkg::PH_TSTART: begin
          if (is_end(c)) return tail_end(c);
          if (d >= 0) begin
            open_group(d, ipta_pkg::PH_GROUP_T);
            return 1'b0;
          end
          return fault(ipta_pkg::ST_HEX_EXP, c);
        end
        ipta_pkg::PH_GROUP_T: begin
          if (d >= 0 && ndig < 3'd4) begin
            more_hex(d);
            return 1'b0;
          end
          if (c == ipta_pkg::CH_DOT && oct_valid()) begin
            enter_v4(ipta_pkg::PH_V4T);
            return 1'b0;
          end
          return seal_tail(c);
        end
        ipta_pkg::PH_TCOLON: begin
          if (d >= 0) begin
            open_group(d, ipta_pkg::PH_GROUP_T);
            return 1'b0;
          end
          return fault(ipta_pkg::ST_HEX_EXP, c);
        end
        ipta_pkg::PH_V4H, ipta_pkg::PH_V4T: begin
          return v4_char(c);
        end
        ipta_pkg::PH_PREFIX: begin
          if (c >= ipta_pkg::CH_ZERO && c <= ipta_pkg::CH_NINE) begin
            t = int'(pfx) * 10 + int'(c - ipta_pkg::CH_ZERO);
            pfx = (t < 255) ? 8'(t) : ipta_pkg::PREFIX_SAT;
            ndig = 3'd1;
            return 1'b0;
          end
          if (ndig == 3'd0 || pfx > ipta_pkg::PREFIX_MAX)
            return fault(ipta_pkg::ST_BAD_PREFIX, c);
          return good(1'b1, pfx, c);
        end
        default: begin
          clear();
          if (c == ipta_pkg::CH_COLON) begin
            ph = ipta_pkg::PH_LCOLON;
            return 1'b0;
          end
          if (d >= 0) begin
            open_group(d, ipta_pkg::PH_GROUP_H);
            return 1'b0;
          end
          return fault(ipta_pkg::ST_HEX_EXP, c);
        end
      endcase
    endfunction

    // accepted input item: a character, then an implied NUL if it is the last and gave no result
    function void take_char(logic [7:0] c, logic is_last);
      if (!decode_char(c) && is_last) void'(decode_char(ipta_pkg::CH_NUL));
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: mismatch on %s, expected %h, got %h", $time, field, want, got);
    endfunction

    function void check_address(ipta_pkg::res_t got);
      ipta_pkg::res_t want;
      if (pending_addrs.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got addr %h_%h status %0d end %h",
                 $time, got.addr_hi, got.addr_lo, got.status, got.end_char);
        return;
      end
      want = pending_addrs.pop_front();
      checked++;
      if (got.addr_hi !== want.addr_hi) flag("addr_hi", want.addr_hi, got.addr_hi);
      if (got.addr_lo !== want.addr_lo) flag("addr_lo", want.addr_lo, got.addr_lo);
      if (got.prefix_len !== want.prefix_len)
        flag("prefix_len", 64'(want.prefix_len), 64'(got.prefix_len));
      if (got.has_prefix !== want.has_prefix)
        flag("has_prefix", 64'(want.has_prefix), 64'(got.has_prefix));
      if (got.status !== want.status) flag("status", 64'(want.status), 64'(got.status));
      if (got.end_char !== want.end_char)
        flag("end_char", 64'(want.end_char), 64'(got.end_char));
    endfunction

    function int pending();
      return pending_addrs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_addr_hi;
  logic [63:0] out_addr_lo;
  logic [7:0]  out_prefix_len;
  logic        out_has_prefix;
  logic [2:0]  out_status;
  logic [7:0]  out_end_char;

  address_scoreboard addr_sb;
  logic [7:0]  addr_text[$];
  bit          text_last;
  int          tx_idle_pct = 19;
  int          rx_idle_pct = 84;
  int          holds_wanted = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          chars_sent = 0;
  int          texts_sent = 0;

  ipv6_text_address_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_addr_hi    (out_addr_hi),
    .out_addr_lo    (out_addr_lo),
    .out_prefix_len (out_prefix_len),
    .out_has_prefix (out_has_prefix),
    .out_status     (out_status),
    .out_end_char   (out_end_char)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_served != holds_wanted) begin
      holds_served = holds_served + 1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    ipta_pkg::res_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) addr_sb.take_char(in_ch, in_last);
      if (out_valid && !out_stall) begin
        seen.addr_hi = out_addr_hi;
        seen.addr_lo = out_addr_lo;
        seen.prefix_len = out_prefix_len;
        seen.has_prefix = out_has_prefix;
        seen.status = out_status;
        seen.end_char = out_end_char;
        addr_sb.check_address(seen);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    @(posedge rst_n);
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_str(input string s, input logic is_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], is_last && i == s.len() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < addr_text.size(); i++)
      send_char(addr_text[i], text_last && i == addr_text.size() - 1);
    texts_sent++;
  endtask

  function automatic void put(logic [7:0] c);
    addr_text.push_back(c);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0: return ipta_pkg::CH_COLON;
      1: return ipta_pkg::CH_DOT;
      2: return ipta_pkg::CH_SLASH;
      3: return 8'($urandom_range(ipta_pkg::CH_ZERO, ipta_pkg::CH_NINE));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_dec(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_group();
    int nd;
    int v;
    nd = ($urandom_range(0, 11) == 0) ? 5 : $urandom_range(1, 4);
    for (int i = 0; i < nd; i++) begin
      v = $urandom_range(0, 15);
      if (v < 10) put(8'(ipta_pkg::CH_ZERO + v));
      else if ($urandom_range(0, 1) != 0) put(8'(ipta_pkg::CH_UA + v - 10));
      else put(8'(ipta_pkg::CH_LA + v - 10));
    end
  endfunction

  function automatic void put_dotted();
    int cnt;
    cnt = ($urandom_range(0, 11) == 0) ? 3 : 4;
    for (int i = 0; i < cnt; i++) begin
      if (i != 0) put(ipta_pkg::CH_DOT);
      case ($urandom_range(0, 9))
        0: put_dec($urandom_range(256, 999));
        1: begin
          put(ipta_pkg::CH_ZERO);
          put_dec($urandom_range(0, 255));
        end
        default: put_dec($urandom_range(0, 255));
      endcase
    end
  endfunction

  // mostly valid address text, sometimes overfull, truncated or corrupted
  function automatic void build_address();
    int  h;
    int  t;
    int  n;
    bit  gap;
    bit  v4;
    addr_text.delete();
    text_last = 1'b0;
    gap = $urandom_range(0, 2) != 0;
    v4 = $urandom_range(0, 3) == 0;
    if (!gap) begin
      n = v4 ? 6 : 8;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        if (i != 0) put(ipta_pkg::CH_COLON);
        put_group();
      end
      if (v4) begin
        put(ipta_pkg::CH_COLON);
        put_dotted();
      end
    end else begin
      h = $urandom_range(0, 7);
      t = $urandom_range(0, 8 - h);
      for (int i = 0; i < h; i++) begin
        if (i != 0) put(ipta_pkg::CH_COLON);
        put_group();
      end
      put(ipta_pkg::CH_COLON);
      put(ipta_pkg::CH_COLON);
      for (int i = 0; i < t; i++) begin
        if (i != 0) put(ipta_pkg::CH_COLON);
        put_group();
      end
      if (v4) begin
        if (t != 0) put(ipta_pkg::CH_COLON);
        put_dotted();
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      put(ipta_pkg::CH_SLASH);
      case ($urandom_range(0, 9))
        0: ;
        1: put_dec($urandom_range(129, 255));
        2: put_dec($urandom_range(256, 999));
        3: begin
          put(ipta_pkg::CH_ZERO);
          put(ipta_pkg::CH_ZERO);
          put_dec($urandom_range(0, 128));
        end
        4: put_dec(128);
        default: put_dec($urandom_range(0, 128));
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: text_last = 1'b1;
      2: put(ipta_pkg::CH_SPACE);
      3: put(ipta_pkg::CH_TAB);
      4: put(ipta_pkg::CH_NUL);
      default: put(noise_char());
    endcase
    if (!text_last && $urandom_range(0, 3) == 0) text_last = 1'b1;
    if ($urandom_range(0, 5) == 0)
      addr_text[$urandom_range(0, addr_text.size() - 1)] = noise_char();
  endfunction

  function automatic void build_noise();
    addr_text.delete();
    repeat ($urandom_range(1, 4)) put(noise_char());
    text_last = 1'($urandom_range(0, 1));
  endfunction

  task automatic run_random(input int upto);
    while (chars_sent < upto) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_address();
      send_text();
    end
  endtask

  initial begin
    addr_sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero prefix, long group, dotted tail, bad char after gap,
    // oversized prefix, extreme bytes at the start of an address
    send_str("::/0 ", 1'b0);
    send_str("abcdE", 1'b0);
    send_str("::1.2.3.4", 1'b1);
    send_str("::1x", 1'b0);
    send_str("::/129", 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(ipta_pkg::CH_NUL, 1'b1);
    send_str("/", 1'b0);

    run_random(200);
    holds_wanted = holds_wanted + 1;
    run_random(400);

    tx_idle_pct = 84;
    rx_idle_pct = 19;
    run_random(800);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_wanted = holds_wanted + 1;
    run_random(1200);

    in_valid <= 1'b0;
    while (addr_sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d characters in %0d texts; %0d results checked, %0d ok (%0d with prefix).",
             chars_sent, texts_sent, addr_sb.checked,
             addr_sb.status_seen[ipta_pkg::ST_OK], addr_sb.with_prefix);
    $display("Errors seen: hex expected %0d, colon expected %0d, overlong %0d, bad prefix %0d.",
             addr_sb.status_seen[ipta_pkg::ST_HEX_EXP],
             addr_sb.status_seen[ipta_pkg::ST_COLON_EXP],
             addr_sb.status_seen[ipta_pkg::ST_OVERLONG],
             addr_sb.status_seen[ipta_pkg::ST_BAD_PREFIX]);
    if (addr_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[ipv6_text_address_parser.f]
rtl/ipta_pkg.sv
rtl/ipta_in_stage.sv
rtl/ipta_engine.sv
rtl/ipta_out_stage.sv
rtl/ipv6_text_address_parser.sv
tb/sv/ipv6_text_address_parser_tb.sv
